[rtl/qenc_pkg.sv]
`timescale 1ns / 1ps

package qenc_pkg;

    localparam int unsigned REC_W = 20;

    localparam logic [1:0] FUNC_QUAL     = 2'd0;
    localparam logic [1:0] FUNC_BIN_READ = 2'd1;
    localparam logic [1:0] FUNC_CLEAR    = 2'd2;

    localparam logic [1:0] MODE_PHRED33    = 2'd0;
    localparam logic [1:0] MODE_SOLEXA     = 2'd1;
    localparam logic [1:0] MODE_ILLUMINA64 = 2'd2;

    localparam logic REG_SOURCE_MODE  = 1'b0;
    localparam logic REG_RECORD_LIMIT = 1'b1;

    localparam logic [1:0]       SOURCE_MODE_RESET  = MODE_PHRED33;
    localparam logic [REC_W-1:0] RECORD_LIMIT_RESET = 20'd100000;
    localparam logic [REC_W-1:0] REC_MAX            = '1;

    localparam logic [7:0] CHAR_BANG  = 8'd33;   // '!'
    localparam logic [7:0] CHAR_SEMI  = 8'd59;   // ';'
    localparam logic [7:0] CHAR_AT    = 8'd64;   // '@'
    localparam logic [7:0] CHAR_B     = 8'd66;   // 'B'
    localparam logic [7:0] CHAR_I     = 8'd73;   // 'I'
    localparam logic [7:0] CHAR_J     = 8'd74;   // 'J'
    localparam logic [7:0] CHAR_LOW_H = 8'd104;  // 'h'

    // rounded 10*log10(10^(s/10) + 1) for s = -9..9
    localparam logic [3:0] SOLEXA_ROM [19] = '{
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3,
        4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10
    };

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] qual_char;
        logic       last_in_record;
        logic [7:0] bin_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  converted_char;
        logic [4:0]  valid_mask;
        logic [2:0]  valid_count;
        logic        decided;
        logic [31:0] bin_count;
    } out_item_t;

    typedef struct packed {
        logic issue;
        logic incr;
        logic clear;
    } hist_cmd_t;

    typedef struct packed {
        logic [4:0] valid_mask;
        logic [2:0] valid_count;
        logic       decided;
    } status_t;

    function automatic logic [7:0] to_phred33(input logic [1:0] mode, input logic [7:0] c);
        logic [7:0] idx;
        logic [7:0] phred;
        logic [7:0] result;
        idx = c - (CHAR_AT - 8'd9);
        if (c >= CHAR_AT + 8'd10)
        begin
            phred = c - CHAR_AT;
        end
        else if (c <= CHAR_AT - 8'd10)
        begin
            phred = 8'd0;
        end
        else
        begin
            phred = {4'd0, SOLEXA_ROM[idx[4:0]]};
        end
        case (mode)
            MODE_SOLEXA:     result = phred + CHAR_BANG;
            MODE_ILLUMINA64: result = c - CHAR_AT + CHAR_BANG;
            default:         result = c;
        endcase
        return result;
    endfunction

endpackage

[rtl/qenc_in_if.sv]
`timescale 1ns / 1ps

interface qenc_in_if;
    logic                valid;
    logic                ready;
    qenc_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/qenc_out_if.sv]
`timescale 1ns / 1ps

interface qenc_out_if;
    logic                valid;
    logic                ready;
    qenc_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/qenc_hist.sv]
`timescale 1ns / 1ps

module qenc_hist #(
    parameter int unsigned HIST_BINS   = 256,
    parameter int unsigned COUNT_WIDTH = 32,
    parameter int unsigned AW          = $clog2(HIST_BINS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  qenc_pkg::hist_cmd_t     cmd,
    input  logic [AW-1:0]           rd_addr,
    input  logic [AW-1:0]           cur_addr,
    output logic [COUNT_WIDTH-1:0]  cur_count
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] mem [HIST_BINS];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [HIST_BINS-1:0]   bin_valid_reg;
    logic                   fwd_valid_reg;
    logic [AW-1:0]          fwd_addr_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;
    logic [COUNT_WIDTH-1:0] wr_data;

    always_comb
    begin
        if (!bin_valid_reg[cur_addr])
        begin
            cur_count = '0;
        end
        else if (fwd_valid_reg && (fwd_addr_reg == cur_addr))
        begin
            cur_count = fwd_data_reg;
        end
        else
        begin
            cur_count = rd_data_reg;
        end
    end

    assign wr_data = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.incr)
        begin
            mem[cur_addr] <= wr_data;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.incr)
        begin
            fwd_addr_reg <= cur_addr;
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            bin_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (cmd.incr)
        begin
            bin_valid_reg[cur_addr] <= 1'b1;
            fwd_valid_reg           <= 1'b1;
        end
    end

endmodule

[rtl/qenc_track.sv]
`timescale 1ns / 1ps

module qenc_track (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        commit,
    input  logic [1:0]                  func,
    input  logic [7:0]                  qual_char,
    input  logic                        last_in_record,
    input  logic [qenc_pkg::REC_W-1:0]  record_limit,
    output qenc_pkg::status_t           status
);

    logic [4:0]                 flags_reg;
    logic [4:0]                 flags_next;
    logic [qenc_pkg::REC_W-1:0] rec_count_reg;
    logic [qenc_pkg::REC_W-1:0] rec_count_next;
    logic [4:0]                 range_flags;
    logic [4:0]                 mask;

    always_comb
    begin
        range_flags[0] = (qual_char < qenc_pkg::CHAR_BANG) || (qual_char > qenc_pkg::CHAR_I);
        range_flags[1] = (qual_char < qenc_pkg::CHAR_SEMI) || (qual_char > qenc_pkg::CHAR_LOW_H);
        range_flags[2] = (qual_char < qenc_pkg::CHAR_AT)   || (qual_char > qenc_pkg::CHAR_LOW_H);
        range_flags[3] = (qual_char < qenc_pkg::CHAR_B)    || (qual_char > qenc_pkg::CHAR_LOW_H);
        range_flags[4] = (qual_char < qenc_pkg::CHAR_BANG) || (qual_char > qenc_pkg::CHAR_J);
    end

    always_comb
    begin
        flags_next     = flags_reg;
        rec_count_next = rec_count_reg;
        if (commit)
        begin
            case (func)
                qenc_pkg::FUNC_QUAL:
                begin
                    flags_next = flags_reg | range_flags;
                    if (last_in_record && (rec_count_reg != qenc_pkg::REC_MAX))
                    begin
                        rec_count_next = rec_count_reg + 1'b1;
                    end
                end
                qenc_pkg::FUNC_CLEAR:
                begin
                    flags_next     = '0;
                    rec_count_next = '0;
                end
                default:
                begin
                    flags_next     = flags_reg;
                    rec_count_next = rec_count_reg;
                end
            endcase
        end
    end

    assign mask               = ~flags_next;
    assign status.valid_mask  = mask;
    assign status.valid_count = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2])
                              + 3'(mask[3]) + 3'(mask[4]);
    assign status.decided     = (status.valid_count == 3'd1) || (rec_count_next >= record_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            rec_count_reg <= '0;
        end
        else
        begin
            flags_reg     <= flags_next;
            rec_count_reg <= rec_count_next;
        end
    end

endmodule

[rtl/fastq_quality_encoding_detect_convert.sv]
`timescale 1ns / 1ps

// FASTQ quality encoding detector and Phred+33 converter.
// chars carries one request per quality character, histogram bin read or
// clear (func); results returns exactly one item per request, in order.
// Each result gives the encodings still valid after the request, their
// count, the decided flag, the character rewritten to Phred+33 under
// source_mode and, for a bin read, the bin count.
// Configuration goes through write_en / write_index / write_data while the
// block is idle: index 0 source_mode, index 1 record_limit.
// A request passes the stage register, where the histogram read is
// registered at acceptance, then the result register, where the update
// and status land. One request is taken every cycle while results does
// not stall; the histogram read-modify-write forwards the last written
// bin to keep pace. Reset clears flags, record counter and all bin valid
// bits at once, so no clearing pass is needed; a clear request does the
// same. When results stalls, the result register holds, the one request
// behind it waits, and chars drops ready until the result is taken.

module fastq_quality_encoding_detect_convert #(
    parameter int unsigned HIST_BINS   = 256,
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        write_en,
    input  logic                        write_index,
    input  logic [qenc_pkg::REC_W-1:0]  write_data,
    qenc_in_if.sink                     chars,
    qenc_out_if.source                  results
);

    localparam int unsigned AW        = $clog2(HIST_BINS);
    localparam logic [8:0]  BIN_LIMIT = 9'(HIST_BINS);

    logic [1:0]                 source_mode_reg;
    logic [qenc_pkg::REC_W-1:0] record_limit_reg;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    qenc_pkg::in_item_t   s1_item_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    qenc_pkg::out_item_t  out_item_reg;
    qenc_pkg::out_item_t  out_item_next;

    logic                   accept;
    logic                   s1_fire;
    logic [7:0]             rd_sel;
    logic [7:0]             cur_sel;
    logic                   cur_in_range;
    qenc_pkg::hist_cmd_t    hist_cmd;
    logic [COUNT_WIDTH-1:0] cur_count;
    qenc_pkg::status_t      status;

    assign s1_fire       = s1_valid_reg && (!out_valid_reg || results.ready);
    assign chars.ready   = !s1_valid_reg || s1_fire;
    assign accept        = chars.valid && chars.ready;
    assign results.valid = out_valid_reg;
    assign results.data  = out_item_reg;

    assign rd_sel  = (chars.data.func == qenc_pkg::FUNC_BIN_READ) ? chars.data.bin_index
                                                                  : chars.data.qual_char;
    assign cur_sel = (s1_item_reg.func == qenc_pkg::FUNC_BIN_READ) ? s1_item_reg.bin_index
                                                                   : s1_item_reg.qual_char;
    assign cur_in_range = ({1'b0, cur_sel} < BIN_LIMIT);

    assign hist_cmd.issue = accept;
    assign hist_cmd.incr  = s1_fire && (s1_item_reg.func == qenc_pkg::FUNC_QUAL) && cur_in_range;
    assign hist_cmd.clear = s1_fire && (s1_item_reg.func == qenc_pkg::FUNC_CLEAR);

    qenc_hist #(
        .HIST_BINS   (HIST_BINS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .AW          (AW)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (hist_cmd),
        .rd_addr   (rd_sel[AW-1:0]),
        .cur_addr  (cur_sel[AW-1:0]),
        .cur_count (cur_count)
    );

    qenc_track u_track (
        .clk            (clk),
        .rst_n          (rst_n),
        .commit         (s1_fire),
        .func           (s1_item_reg.func),
        .qual_char      (s1_item_reg.qual_char),
        .last_in_record (s1_item_reg.last_in_record),
        .record_limit   (record_limit_reg),
        .status         (status)
    );

    always_comb
    begin
        out_item_next.valid_mask  = status.valid_mask;
        out_item_next.valid_count = status.valid_count;
        out_item_next.decided     = status.decided;
        out_item_next.converted_char = (s1_item_reg.func == qenc_pkg::FUNC_QUAL)
            ? qenc_pkg::to_phred33(source_mode_reg, s1_item_reg.qual_char) : 8'd0;
        out_item_next.bin_count = ((s1_item_reg.func == qenc_pkg::FUNC_BIN_READ) && cur_in_range)
            ? 32'(cur_count) : 32'd0;
    end

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_fire ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= chars.data;
        end
        if (s1_fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_mode_reg  <= qenc_pkg::SOURCE_MODE_RESET;
            record_limit_reg <= qenc_pkg::RECORD_LIMIT_RESET;
        end
        else if (write_en)
        begin
            unique case (write_index)
                qenc_pkg::REG_SOURCE_MODE:  source_mode_reg  <= write_data[1:0];
                qenc_pkg::REG_RECORD_LIMIT: record_limit_reg <= write_data;
                default:                    record_limit_reg <= record_limit_reg;
            endcase
        end
    end

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !results.ready
        |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("waiting request changed while result stalled");

    a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_item_reg.valid_count == 3'($countones(out_item_reg.valid_mask)))
        else $error("valid_count disagrees with valid_mask");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        hist_cmd.clear |=> out_valid_reg && (out_item_reg.valid_mask == 5'h1f)
                           && (out_item_reg.bin_count == 32'd0))
        else $error("clear did not report a cleared state");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !results.ready |=> out_valid_reg && $stable(out_item_reg))
        else $error("result register overwritten while stalled");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] FUNC_UNDEF = 2'd3;
    localparam logic [1:0] MODE_UNDEF = 2'd3;

    localparam logic [7:0] SOLEXA_Q [19] = '{
        8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd3, 8'd3,
        8'd4, 8'd4, 8'd5, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10
    };

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_EVERY_FOURTH,
        STALL_LONG
    } stall_style_t;

    logic                        clk;
    logic                        rst_n;
    logic                        write_en;
    logic                        write_index;
    logic [qenc_pkg::REC_W-1:0]  write_data;

    qenc_in_if  chars_if ();
    qenc_out_if results_if ();

    fastq_quality_encoding_detect_convert u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .chars       (chars_if),
        .results     (results_if)
    );

    // shadow copy of the block's state and registers
    logic [4:0]                  ruled_out;
    logic [31:0]                 char_hist [256];
    logic [qenc_pkg::REC_W-1:0]  rec_count;
    logic [1:0]                  src_mode;
    logic [qenc_pkg::REC_W-1:0]  rec_limit;

    qenc_pkg::out_item_t         pending_results [$];
    qenc_pkg::out_item_t         want_item;
    qenc_pkg::out_item_t         got_item;
    int                          errors;
    int                          items_sent;
    int                          burst_left;
    logic [7:0]                  recent_char;

    stall_style_t                stall_style;
    int                          style_left;
    int                          stall_hold;
    int                          stall_phase;

    logic [7:0]                  enc_lo [5];
    logic [7:0]                  enc_hi [5];

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [7:0] phred33_of(input logic [7:0] c);
        int         s;
        logic [7:0] q;
        s = int'(c) - 64;
        if (s >= 10)
        begin
            q = 8'(s);
        end
        else if (s <= -10)
        begin
            q = 8'd0;
        end
        else
        begin
            q = SOLEXA_Q[s + 9];
        end
        case (src_mode)
            qenc_pkg::MODE_SOLEXA:     return q + qenc_pkg::CHAR_BANG;
            qenc_pkg::MODE_ILLUMINA64: return c - qenc_pkg::CHAR_AT + qenc_pkg::CHAR_BANG;
            default:                   return c;
        endcase
    endfunction

    function automatic qenc_pkg::out_item_t detect_and_convert(input qenc_pkg::in_item_t it);
        qenc_pkg::out_item_t r;
        logic [7:0]          c;
        c = it.qual_char;
        r = '0;
        case (it.func)
            qenc_pkg::FUNC_QUAL:
            begin
                ruled_out[0] = ruled_out[0] | (c < qenc_pkg::CHAR_BANG)
                             | (c > qenc_pkg::CHAR_I);
                ruled_out[1] = ruled_out[1] | (c < qenc_pkg::CHAR_SEMI)
                             | (c > qenc_pkg::CHAR_LOW_H);
                ruled_out[2] = ruled_out[2] | (c < qenc_pkg::CHAR_AT)
                             | (c > qenc_pkg::CHAR_LOW_H);
                ruled_out[3] = ruled_out[3] | (c < qenc_pkg::CHAR_B)
                             | (c > qenc_pkg::CHAR_LOW_H);
                ruled_out[4] = ruled_out[4] | (c < qenc_pkg::CHAR_BANG)
                             | (c > qenc_pkg::CHAR_J);
                if (char_hist[c] != 32'hFFFF_FFFF)
                begin
                    char_hist[c] = char_hist[c] + 32'd1;
                end
                if (it.last_in_record && rec_count != qenc_pkg::REC_MAX)
                begin
                    rec_count = rec_count + 1'b1;
                end
                r.converted_char = phred33_of(c);
            end
            qenc_pkg::FUNC_BIN_READ:
            begin
                r.bin_count = char_hist[it.bin_index];
            end
            qenc_pkg::FUNC_CLEAR:
            begin
                ruled_out = '0;
                foreach (char_hist[i])
                begin
                    char_hist[i] = '0;
                end
                rec_count = '0;
            end
            default:
            begin
            end
        endcase
        r.valid_mask  = ~ruled_out;
        r.valid_count = 3'($countones(r.valid_mask));
        r.decided     = (r.valid_count == 3'd1) || (rec_count >= rec_limit);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (write_en)
            begin
                case (write_index)
                    qenc_pkg::REG_SOURCE_MODE:  src_mode  = write_data[1:0];
                    qenc_pkg::REG_RECORD_LIMIT: rec_limit = write_data;
                endcase
            end
            if (results_if.valid && results_if.ready)
            begin
                got_item = results_if.data;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with none outstanding, expected none actual %0h",
                             $time, got_item);
                    errors++;
                end
                else
                begin
                    want_item = pending_results.pop_front();
                    check_field("converted_char", want_item.converted_char,
                                got_item.converted_char);
                    check_field("valid_mask", want_item.valid_mask, got_item.valid_mask);
                    check_field("valid_count", want_item.valid_count, got_item.valid_count);
                    check_field("decided", want_item.decided, got_item.decided);
                    check_field("bin_count", want_item.bin_count, got_item.bin_count);
                end
            end
            if (chars_if.valid && chars_if.ready)
            begin
                pending_results.push_back(detect_and_convert(chars_if.data));
            end
        end
    end

    always @(negedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            style_left  = $urandom_range(40, 200);
        end
        style_left--;
        stall_phase++;
        case (stall_style)
            STALL_NONE:         results_if.ready <= 1'b1;
            STALL_COIN:         results_if.ready <= 1'($urandom_range(0, 1));
            STALL_EVERY_FOURTH: results_if.ready <= (stall_phase % 4 == 0);
            default:
            begin
                if (stall_hold > 0)
                begin
                    stall_hold--;
                    results_if.ready <= 1'b0;
                end
                else
                begin
                    results_if.ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                    begin
                        stall_hold = $urandom_range(1, 15);
                    end
                end
            end
        endcase
    end

    task automatic send_item(input qenc_pkg::in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                chars_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge clk);
        chars_if.valid <= 1'b1;
        chars_if.data  <= it;
        do
            @(posedge clk);
        while (!chars_if.ready);
        burst_left--;
        items_sent++;
        if (it.func == qenc_pkg::FUNC_QUAL)
        begin
            recent_char = it.qual_char;
        end
    endtask

    task automatic send_fields(input logic [1:0] func, input logic [7:0] c,
                               input logic last, input logic [7:0] bin);
        qenc_pkg::in_item_t it;
        it.func           = func;
        it.qual_char      = c;
        it.last_in_record = last;
        it.bin_index      = bin;
        send_item(it);
    endtask

    // drain all outstanding results, then let the pipeline empty
    task automatic settle();
        @(negedge clk);
        chars_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [qenc_pkg::REC_W-1:0] value);
        @(negedge clk);
        write_en    <= 1'b1;
        write_index <= idx;
        write_data  <= value;
        @(negedge clk);
        write_en    <= 1'b0;
    endtask

    task automatic set_mode(input logic [1:0] mode);
        write_reg(qenc_pkg::REG_SOURCE_MODE, {18'($urandom), mode});
    endtask

    task automatic test_reset_state();
        send_fields(FUNC_UNDEF, 8'hFF, 1'b1, 8'hFF);
        send_fields(qenc_pkg::FUNC_BIN_READ, 8'h00, 1'b0, 8'h00);
    endtask

    task automatic test_range_edges();
        send_fields(qenc_pkg::FUNC_CLEAR, 8'h00, 1'b0, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, qenc_pkg::CHAR_BANG, 1'b0, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, qenc_pkg::CHAR_J, 1'b1, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, qenc_pkg::CHAR_I, 1'b0, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, qenc_pkg::CHAR_J + 8'd1, 1'b0, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, qenc_pkg::CHAR_SEMI, 1'b0, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, qenc_pkg::CHAR_AT - 8'd1, 1'b0, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, qenc_pkg::CHAR_B - 8'd1, 1'b0, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, qenc_pkg::CHAR_LOW_H + 8'd1, 1'b1, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, 8'h00, 1'b0, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, 8'hFF, 1'b0, 8'h00);
        send_fields(qenc_pkg::FUNC_BIN_READ, 8'h00, 1'b0, qenc_pkg::CHAR_J);
    endtask

    task automatic test_conversion();
        settle();
        set_mode(qenc_pkg::MODE_SOLEXA);
        send_fields(qenc_pkg::FUNC_QUAL, qenc_pkg::CHAR_AT - 8'd10, 1'b0, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, qenc_pkg::CHAR_AT - 8'd9, 1'b0, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, qenc_pkg::CHAR_AT + 8'd9, 1'b0, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, qenc_pkg::CHAR_AT + 8'd10, 1'b0, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, 8'hFF, 1'b0, 8'h00);
        settle();
        set_mode(qenc_pkg::MODE_ILLUMINA64);
        send_fields(qenc_pkg::FUNC_QUAL, 8'h00, 1'b0, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, 8'hFF, 1'b0, 8'h00);
        settle();
        set_mode(MODE_UNDEF);
        send_fields(qenc_pkg::FUNC_QUAL, 8'hC8, 1'b0, 8'h00);
    endtask

    task automatic test_record_limit();
        settle();
        write_reg(qenc_pkg::REG_RECORD_LIMIT, '0);
        send_fields(qenc_pkg::FUNC_BIN_READ, 8'h00, 1'b0, 8'hFF);
        settle();
        write_reg(qenc_pkg::REG_RECORD_LIMIT, 20'd1);
        send_fields(qenc_pkg::FUNC_CLEAR, 8'h00, 1'b0, 8'h00);
        send_fields(qenc_pkg::FUNC_QUAL, qenc_pkg::CHAR_I, 1'b1, 8'h00);
        settle();
        write_reg(qenc_pkg::REG_RECORD_LIMIT, qenc_pkg::REC_MAX);
        send_fields(qenc_pkg::FUNC_QUAL, qenc_pkg::CHAR_I, 1'b1, 8'h00);
    endtask

    task automatic send_record(input int enc);
        int         len;
        logic [7:0] c;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                c = 8'($urandom);
            end
            else
            begin
                c = 8'($urandom_range(enc_lo[enc], enc_hi[enc]));
            end
            send_fields(qenc_pkg::FUNC_QUAL, c, i == len - 1, 8'($urandom));
        end
    endtask

    task automatic send_session();
        int kind;
        int enc;
        int n;
        kind = $urandom_range(0, 9);
        if (kind <= 6)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                send_fields(qenc_pkg::FUNC_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom));
            end
            enc = $urandom_range(0, 4);
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                send_record(enc);
                if ($urandom_range(0, 2) == 0)
                begin
                    send_fields(qenc_pkg::FUNC_BIN_READ, 8'($urandom), 1'($urandom),
                                recent_char);
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    send_fields(FUNC_UNDEF, 8'($urandom), 1'($urandom), 8'($urandom));
                end
            end
        end
        else if (kind == 7)
        begin
            send_fields(qenc_pkg::FUNC_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom));
        end
        else if (kind == 8)
        begin
            repeat ($urandom_range(1, 5))
                send_item(qenc_pkg::in_item_t'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                send_fields(qenc_pkg::FUNC_BIN_READ, 8'($urandom), 1'($urandom),
                            ($urandom_range(0, 1) == 0) ? recent_char : 8'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic(input logic [1:0] mode,
                                       input logic [qenc_pkg::REC_W-1:0] limit,
                                       input int n);
        int stop_at;
        settle();
        set_mode(mode);
        write_reg(qenc_pkg::REG_RECORD_LIMIT, limit);
        stop_at = items_sent + n;
        while (items_sent < stop_at)
            send_session();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        write_en         = 1'b0;
        write_index      = 1'b0;
        write_data       = '0;
        chars_if.valid   = 1'b0;
        chars_if.data    = '0;
        results_if.ready = 1'b0;
        errors           = 0;
        items_sent       = 0;
        burst_left       = 0;
        recent_char      = '0;
        style_left       = 0;
        stall_hold       = 0;
        stall_phase      = 0;
        ruled_out        = '0;
        rec_count        = '0;
        src_mode         = qenc_pkg::SOURCE_MODE_RESET;
        rec_limit        = qenc_pkg::RECORD_LIMIT_RESET;
        foreach (char_hist[i])
        begin
            char_hist[i] = '0;
        end
        enc_lo = '{qenc_pkg::CHAR_BANG, qenc_pkg::CHAR_SEMI, qenc_pkg::CHAR_AT,
                   qenc_pkg::CHAR_B, qenc_pkg::CHAR_BANG};
        enc_hi = '{qenc_pkg::CHAR_I, qenc_pkg::CHAR_LOW_H, qenc_pkg::CHAR_LOW_H,
                   qenc_pkg::CHAR_LOW_H, qenc_pkg::CHAR_J};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_range_edges();
        test_conversion();
        test_record_limit();

        test_random_traffic(qenc_pkg::MODE_SOLEXA, 20'd1, 75);
        test_random_traffic(qenc_pkg::MODE_ILLUMINA64, qenc_pkg::REC_MAX, 75);
        test_random_traffic(qenc_pkg::MODE_PHRED33, 20'd3, 75);
        test_random_traffic(MODE_UNDEF, '0, 75);
        test_random_traffic(qenc_pkg::MODE_SOLEXA, qenc_pkg::RECORD_LIMIT_RESET, 75);
        test_random_traffic(qenc_pkg::MODE_ILLUMINA64, 20'($urandom_range(2, 20)), 75);
        test_random_traffic(qenc_pkg::MODE_PHRED33, 20'($urandom), 75);
        test_random_traffic(qenc_pkg::MODE_SOLEXA, 20'd5, 75);

        settle();
        if (errors == 0)
        begin
            $display("[fastq_quality_encoding_detect_convert] OK");
        end
        else
        begin
            $display("[fastq_quality_encoding_detect_convert] ERROR");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[fastq_quality_encoding_detect_convert] ERROR");
        $finish;
    end

endmodule
